// ===== rtl/core/dbpm_pkg.sv =====
// package for the backlight power manager: payload types, mode and register codes
// no dependencies
`default_nettype none
package dbpm_pkg;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        touch_valid;
      logic        touch_down;
      logic [9:0]  touch_x;
      logic [9:0]  touch_y;
      logic        status_valid;
      logic [31:0] status_signature;
      logic [1:0]  severity;
   } req_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic       brightness_write;
      logic [1:0] display_mode;
      logic       fading;
      logic       pointer_pressed;
      logic [9:0] pointer_x;
      logic [9:0] pointer_y;
      logic       ui_refresh;
   } rsp_type;

   localparam logic [1:0] MODE_AWAKE = 2'd0;
   localparam logic [1:0] MODE_DIM   = 2'd1;
   localparam logic [1:0] MODE_OFF   = 2'd2;

   localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_DIM_TIMEOUT  = 3'd1;
   localparam logic [2:0] REG_AWAKE_LEVEL  = 3'd2;
   localparam logic [2:0] REG_DIM_LEVEL    = 3'd3;
   localparam logic [2:0] REG_FADE_TIME    = 3'd4;
   localparam logic [2:0] REG_SNOOZE_TIME  = 3'd5;
   localparam logic [2:0] REG_WAKE_GUARD   = 3'd6;
   localparam logic [2:0] REG_LONG_PRESS   = 3'd7;

   localparam int          CSR_ADDR_W = 4;
   localparam int          DIV_STEPS  = 24;
   localparam logic [4:0]  DIV_LAST   = 5'(DIV_STEPS - 1);

   typedef struct packed {
      logic load;    // capture the beat, run touch handling, start divide
      logic step;    // one divider iteration
      logic finish;  // fade, status, timers and the result register
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

   typedef struct packed {
      logic [31:0] idle_timeout_ms;
      logic [31:0] dim_timeout_ms;
      logic [7:0]  awake_level;
      logic [7:0]  dim_level;
      logic [15:0] fade_time_ms;
      logic [31:0] snooze_time_ms;
      logic [15:0] wake_guard_ms;
      logic [15:0] long_press_ms;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/core/dbpm_ctrl.sv =====
// controller for the backlight power manager: sequences load, divide and finish
// depends on dbpm_pkg
`default_nettype none
module dbpm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire dbpm_pkg::sts_type sts,
   output dbpm_pkg::cmd_type      cmd
);
   import dbpm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept, out_free;

   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      valid_in   = valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_load_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DIV)) else $error("load did not start divide");
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish without result");
   a_state_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) || (state_ff == ST_DIV) || (state_ff == ST_FIN))
      else $error("bad state");
endmodule
`default_nettype wire

// ===== rtl/core/dbpm_datapath.sv =====
// datapath for the backlight power manager: state registers, divider, timers
// depends on dbpm_pkg
`default_nettype none
module dbpm_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dbpm_pkg::cfg_type cfg,
   input  wire dbpm_pkg::req_type req_data,
   input  wire dbpm_pkg::cmd_type cmd,
   output dbpm_pkg::sts_type      sts,
   output dbpm_pkg::rsp_type      rsp_data
);
   import dbpm_pkg::*;

   // persistent state
   logic [1:0]  mode_ff, mode_in, goal_mode_ff, goal_mode_in, sev_ff, sev_in;
   logic        fade_on_ff, fade_on_in, snooze_on_ff, snooze_on_in;
   logic        armed_ff, armed_in, hold_act_ff, hold_act_in, hold_fired_ff, hold_fired_in;
   logic        standby_ff, standby_in, seen_ff, seen_in;
   logic [7:0]  lvl_ff, lvl_in, from_ff, from_in, goal_ff, goal_in;
   logic [31:0] fbegin_ff, fbegin_in, off_since_ff, off_since_in;
   logic [31:0] dim_since_ff, dim_since_in, act_ff, act_in;
   logic [31:0] snz_end_ff, snz_end_in, hold_begin_ff, hold_begin_in;
   logic [31:0] last_sig_ff, last_sig_in, snz_sig_ff, snz_sig_in;

   // per-beat registers
   req_type     beat_ff;
   logic        fwd_ff, refresh_ff, wrote_ff;
   logic        t_fwd, t_refresh;
   logic [15:0] elapsed_ff;
   logic        short_ff;
   logic        neg_ff;
   logic [23:0] quo_ff, rem_ff;
   logic [4:0]  cnt_ff;
   rsp_type     rsp_ff;

   // touch stage results (load cycle), applied to the state
   logic [1:0]  t_mode;
   logic        t_fade_on, t_snz_on, t_armed, t_hact, t_hfired;
   logic [1:0]  t_gmode;
   logic [7:0]  t_from, t_goal;
   logic [31:0] t_fbegin, t_dim, t_act, t_snz_end, t_hbegin, t_snz_sig;
   logic [31:0] now, elapsed32;
   logic        pressed;
   logic [8:0]  t_delta, delta_abs;
   logic [23:0] t_dividend;

   assign now     = req_data.now_ms;
   assign pressed = req_data.touch_down;

   always_comb begin
      t_mode = mode_ff; t_fade_on = fade_on_ff; t_snz_on = snooze_on_ff;
      t_armed = armed_ff; t_hact = hold_act_ff; t_hfired = hold_fired_ff;
      t_gmode = goal_mode_ff; t_from = from_ff; t_goal = goal_ff;
      t_fbegin = fbegin_ff; t_dim = dim_since_ff; t_act = act_ff;
      t_snz_end = snz_end_ff; t_hbegin = hold_begin_ff; t_snz_sig = snz_sig_ff;
      t_fwd = 1'b0; t_refresh = 1'b0;
      if (req_data.touch_valid) begin
         if (pressed && (mode_ff == MODE_DIM || mode_ff == MODE_OFF)) begin
            t_act = now; t_snz_on = 1'b0;
            if (!(mode_ff == MODE_OFF && (now - off_since_ff) <= {16'd0, cfg.wake_guard_ms}))
            begin
               if (!(mode_ff == MODE_AWAKE && !fade_on_ff)) begin
                  if (mode_ff == MODE_OFF) t_refresh = 1'b1;
                  t_armed = 1'b1; t_fade_on = 1'b1; t_gmode = MODE_AWAKE;
                  t_from = lvl_ff; t_goal = cfg.awake_level; t_fbegin = now;
               end
            end
         end else if (armed_ff) begin
            if (!pressed) t_armed = 1'b0;
         end else if (pressed && hold_fired_ff) begin
         end else if (!pressed) begin
            t_hact = 1'b0; t_hfired = 1'b0;
         end else begin
            t_act = now; t_snz_on = 1'b0;
            if (!hold_act_ff) begin
               t_hact = 1'b1; t_hfired = 1'b0; t_hbegin = now; t_fwd = 1'b1;
            end else if ((now - hold_begin_ff) >= {16'd0, cfg.long_press_ms}) begin
               t_hfired = 1'b1; t_snz_sig = last_sig_ff; t_snz_on = 1'b1;
               t_snz_end = now + cfg.snooze_time_ms;
               if (!(mode_ff == MODE_OFF && !fade_on_ff)) begin
                  t_fade_on = 1'b1; t_gmode = MODE_OFF; t_from = lvl_ff;
                  t_goal = 8'd0; t_fbegin = now;
               end
            end else begin
               t_fwd = 1'b1;
            end
         end
      end
      elapsed32  = now - t_fbegin;
      t_delta    = {1'b0, t_goal} - {1'b0, t_from};
      delta_abs  = t_delta[8] ? 9'(-t_delta) : t_delta;
      t_dividend = {16'd0, delta_abs[7:0]} * {8'd0, elapsed32[15:0]};
   end

   // restoring divider, one quotient bit per step
   logic [24:0] trial;
   assign trial = {rem_ff, quo_ff[23]} - {9'd0, cfg.fade_time_ms};
   assign sts.div_done = (cnt_ff == DIV_LAST);

   // finish stage: fade, status, timers
   logic [7:0]  f_step, f_next;
   logic        crit;
   logic [31:0] snz_d;
   always_comb begin
      mode_in = t_mode; fade_on_in = t_fade_on; snooze_on_in = t_snz_on;
      armed_in = t_armed; hold_act_in = t_hact; hold_fired_in = t_hfired;
      goal_mode_in = t_gmode; from_in = t_from; goal_in = t_goal;
      fbegin_in = t_fbegin; dim_since_in = t_dim; act_in = t_act;
      snz_end_in = t_snz_end; hold_begin_in = t_hbegin; snz_sig_in = t_snz_sig;
      off_since_in = off_since_ff; lvl_in = lvl_ff; sev_in = sev_ff;
      standby_in = standby_ff; seen_in = seen_ff; last_sig_in = last_sig_ff;
      f_step = neg_ff ? 8'(-quo_ff[7:0]) : quo_ff[7:0];
      f_next = from_ff + f_step;
      crit = 1'b0; snz_d = '0;
      rsp_data = rsp_ff;
      if (cmd.finish) begin
         // state regs already hold the touch results here
         mode_in = mode_ff; fade_on_in = fade_on_ff; snooze_on_in = snooze_on_ff;
         armed_in = armed_ff; hold_act_in = hold_act_ff; hold_fired_in = hold_fired_ff;
         goal_mode_in = goal_mode_ff; from_in = from_ff; goal_in = goal_ff;
         fbegin_in = fbegin_ff; dim_since_in = dim_since_ff; act_in = act_ff;
         snz_end_in = snz_end_ff; hold_begin_in = hold_begin_ff; snz_sig_in = snz_sig_ff;
         rsp_data.ui_refresh = refresh_ff;
         rsp_data.brightness_write = 1'b0;
         if (fade_on_ff) begin
            if (short_ff) begin
               fade_on_in = 1'b0; lvl_in = goal_ff; rsp_data.brightness_write = 1'b1;
               mode_in = goal_mode_ff;
               if (goal_mode_ff == MODE_OFF) begin
                  off_since_in = beat_ff.now_ms; armed_in = 1'b0;
               end
            end else if (f_next != lvl_ff) begin
               lvl_in = f_next; rsp_data.brightness_write = 1'b1;
            end
         end
         if (beat_ff.status_valid) begin
            sev_in = (beat_ff.severity == 2'd3) ? 2'd0 : beat_ff.severity;
            if (!seen_ff) begin
               seen_in = 1'b1; standby_in = 1'b1;
               act_in = beat_ff.now_ms; snooze_on_in = 1'b0;
            end else if (beat_ff.status_signature != last_sig_ff) begin
               act_in = beat_ff.now_ms;
               if (snooze_on_in && beat_ff.status_signature != snz_sig_ff)
                  snooze_on_in = 1'b0;
               if ((sev_in == 2'd1 || sev_in == 2'd2)
                   && !(mode_in == MODE_AWAKE && !fade_on_in)) begin
                  if (mode_in == MODE_OFF) rsp_data.ui_refresh = 1'b1;
                  armed_in = 1'b1; fade_on_in = 1'b1; goal_mode_in = MODE_AWAKE;
                  from_in = lvl_in; goal_in = cfg.awake_level;
                  fbegin_in = beat_ff.now_ms;
               end
            end
            last_sig_in = beat_ff.status_signature;
         end
         crit  = (sev_in == 2'd2);
         snz_d = snz_end_in - beat_ff.now_ms;
         if (standby_in) begin
            if (snooze_on_in && snz_d != 32'd0 && !snz_d[31]) begin
            end else if (snooze_on_in && crit) begin
               snooze_on_in = 1'b0;
               if (!(mode_in == MODE_DIM && !fade_on_in)) begin
                  if (mode_in == MODE_OFF) rsp_data.ui_refresh = 1'b1;
                  fade_on_in = 1'b1; goal_mode_in = MODE_DIM; from_in = lvl_in;
                  goal_in = cfg.dim_level; fbegin_in = beat_ff.now_ms;
                  dim_since_in = beat_ff.now_ms;
               end
            end else begin
               snooze_on_in = 1'b0;
               if (mode_in == MODE_AWAKE
                   && (beat_ff.now_ms - act_in) >= cfg.idle_timeout_ms) begin
                  if (fade_on_in) begin
                     fade_on_in = 1'b1; goal_mode_in = MODE_DIM; from_in = lvl_in;
                     goal_in = cfg.dim_level; fbegin_in = beat_ff.now_ms;
                     dim_since_in = beat_ff.now_ms;
                  end else begin
                     fade_on_in = 1'b1; goal_mode_in = MODE_DIM; from_in = lvl_in;
                     goal_in = cfg.dim_level; fbegin_in = beat_ff.now_ms;
                     dim_since_in = beat_ff.now_ms;
                  end
               end else if (mode_in == MODE_DIM && !crit
                   && (beat_ff.now_ms - dim_since_in) >= cfg.dim_timeout_ms) begin
                  fade_on_in = 1'b1; goal_mode_in = MODE_OFF; from_in = lvl_in;
                  goal_in = 8'd0; fbegin_in = beat_ff.now_ms;
               end
            end
         end
         rsp_data.brightness       = lvl_in;
         rsp_data.display_mode     = mode_in;
         rsp_data.fading           = fade_on_in;
         rsp_data.pointer_pressed  = fwd_ff;
         rsp_data.pointer_x        = fwd_ff ? beat_ff.touch_x : 10'd0;
         rsp_data.pointer_y        = fwd_ff ? beat_ff.touch_y : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         beat_ff    <= req_data;
         fwd_ff     <= t_fwd;
         refresh_ff <= t_refresh;
         short_ff   <= (cfg.fade_time_ms == 16'd0)
                       || (elapsed32 >= {16'd0, cfg.fade_time_ms});
         elapsed_ff <= elapsed32[15:0];
         neg_ff     <= t_delta[8];
         quo_ff     <= t_dividend;
         rem_ff     <= '0;
         cnt_ff     <= '0;
      end else if (cmd.step) begin
         if (!trial[24]) rem_ff <= trial[23:0];
         else rem_ff <= {rem_ff[22:0], quo_ff[23]};
         quo_ff <= {quo_ff[22:0], !trial[24]};
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.finish) rsp_ff <= rsp_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_AWAKE; goal_mode_ff <= MODE_AWAKE; sev_ff <= 2'd0;
         fade_on_ff <= 1'b0; snooze_on_ff <= 1'b0; armed_ff <= 1'b0;
         hold_act_ff <= 1'b0; hold_fired_ff <= 1'b0; standby_ff <= 1'b0;
         seen_ff <= 1'b0;
         lvl_ff <= 8'd160; from_ff <= 8'd160; goal_ff <= 8'd160;
         fbegin_ff <= '0; off_since_ff <= '0; dim_since_ff <= '0; act_ff <= '0;
         snz_end_ff <= '0; hold_begin_ff <= '0; last_sig_ff <= '0; snz_sig_ff <= '0;
      end else if (cmd.load || cmd.finish) begin
         mode_ff <= mode_in; goal_mode_ff <= goal_mode_in; sev_ff <= sev_in;
         fade_on_ff <= fade_on_in; snooze_on_ff <= snooze_on_in; armed_ff <= armed_in;
         hold_act_ff <= hold_act_in; hold_fired_ff <= hold_fired_in;
         standby_ff <= standby_in; seen_ff <= seen_in;
         lvl_ff <= lvl_in; from_ff <= from_in; goal_ff <= goal_in;
         fbegin_ff <= fbegin_in; off_since_ff <= off_since_in;
         dim_since_ff <= dim_since_in; act_ff <= act_in;
         snz_end_ff <= snz_end_in; hold_begin_ff <= hold_begin_in;
         last_sig_ff <= last_sig_in; snz_sig_ff <= snz_sig_in;
      end
   end

   a_quo_fits: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && fade_on_ff && !short_ff) |-> (quo_ff[23:8] == 16'd0))
      else $error("ramp step out of range");
   a_short: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && fade_on_ff && !short_ff) |-> (elapsed_ff < cfg.fade_time_ms))
      else $error("ramp elapsed past fade time");
   a_off_level: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && mode_in == MODE_OFF && !fade_on_in) |-> (lvl_in == 8'd0))
      else $error("off mode with backlight lit");
endmodule
`default_nettype wire

// ===== rtl/core/display_backlight_power_manager.sv =====
// top level of the backlight power manager: config registers, controller, datapath
// depends on dbpm_pkg, dbpm_ctrl, dbpm_datapath
//
// usage: one req beat per main-loop pass (timestamp, optional touch sample,
// optional status signature and severity); one rsp beat per req beat with
// the brightness, write strobe, committed mode, fade flag, forwarded pointer
// and ui refresh flag. csr writes (index, data) land when csr_valid and
// csr_ready are high; csr_ready is always high, unknown indexes are ignored.
// rsp_valid rises after the load step, the steps of the bit-serial fade
// divider, then the finish step that loads the output register. a new beat is
// taken only after the previous one finishes; req_stall is high while a beat
// is in work. when rsp_stall holds the output register, the finish step waits,
// so nothing is lost.
// reset (synchronous, active high) restores register defaults: awake mode,
// brightness 160, no fade, standby disabled until the first status beat.
`default_nettype none
module display_backlight_power_manager (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire dbpm_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output dbpm_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [dbpm_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [31:0]                     csr_wdata
);
   import dbpm_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_next;
   logic    rsp_vld;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout_ms <= 32'd300000;
         cfg_ff.dim_timeout_ms  <= 32'd30000;
         cfg_ff.awake_level     <= 8'd160;
         cfg_ff.dim_level       <= 8'd24;
         cfg_ff.fade_time_ms    <= 16'd400;
         cfg_ff.snooze_time_ms  <= 32'd1800000;
         cfg_ff.wake_guard_ms   <= 16'd1000;
         cfg_ff.long_press_ms   <= 16'd3000;
      end else if (csr_valid && csr_index[3] == 1'b0) begin
         case (csr_index[2:0])
            REG_IDLE_TIMEOUT: cfg_ff.idle_timeout_ms <= csr_wdata;
            REG_DIM_TIMEOUT:  cfg_ff.dim_timeout_ms  <= csr_wdata;
            REG_AWAKE_LEVEL:  cfg_ff.awake_level     <= csr_wdata[7:0];
            REG_DIM_LEVEL:    cfg_ff.dim_level       <= csr_wdata[7:0];
            REG_FADE_TIME:    cfg_ff.fade_time_ms    <= csr_wdata[15:0];
            REG_SNOOZE_TIME:  cfg_ff.snooze_time_ms  <= csr_wdata;
            REG_WAKE_GUARD:   cfg_ff.wake_guard_ms   <= csr_wdata[15:0];
            REG_LONG_PRESS:   cfg_ff.long_press_ms   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   dbpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_vld),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dbpm_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_next)
   );

   rsp_type rsp_hold_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_hold_ff <= rsp_next;
   end

   assign rsp_valid = rsp_vld;
   assign rsp_data  = rsp_hold_ff;
endmodule
`default_nettype wire
